// ----- hdl/rct_pkg.sv -----
// Shared types and constants for the replay counter table.
// Holds the transfer payload structs, the scan token that walks the cell row,
// the table write command and the verdict codes. No dependencies.
`default_nettype none

package rct_pkg;

  // Default number of table entries; the index fields cover up to 64 entries.
  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int IDX_W = 6;

  typedef logic [IDX_W-1:0] idx_t;

  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [2:0] V_ADVANCED  = 3'd0;
  localparam logic [2:0] V_REBOOT    = 3'd1;
  localparam logic [2:0] V_REJECTED  = 3'd2;
  localparam logic [2:0] V_UNTRACKED = 3'd3;
  localparam logic [2:0] V_QHIT      = 3'd4;
  localparam logic [2:0] V_QMISS     = 3'd5;

  typedef struct packed {
    logic        func;
    logic [31:0] node_id;
    logic [31:0] boot_value;
    logic [15:0] frame_count;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  verdict;
    logic [15:0] stored_count;
  } rsp_t;

  // Token that moves one cell per cycle and gathers the lookup result.
  typedef struct packed {
    logic        valid;
    logic        hit;
    idx_t        hit_idx;
    logic [31:0] hit_boot;
    logic [15:0] hit_count;
    logic        free_hit;
    idx_t        free_idx;
  } scan_t;

  // Broadcast write into one entry of the row.
  typedef struct packed {
    logic        en;
    idx_t        idx;
    logic [31:0] node;
    logic [31:0] boot;
    logic [15:0] count;
  } wr_t;

endpackage

`default_nettype wire

// ----- hdl/rct_cell.sv -----
// One entry of the replay counter table and its stage of the lookup chain.
// Depends on rct_pkg for the scan token and write command types.
`default_nettype none

module rct_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [31:0]    node_id,
  input  wire rct_pkg::scan_t scan_in,
  input  wire rct_pkg::wr_t   wr,
  output rct_pkg::scan_t      scan_out
);

  localparam rct_pkg::idx_t MY_IDX = CELL_IDX[rct_pkg::IDX_W-1:0];

  logic        valid;
  logic [31:0] node;
  logic [31:0] boot;
  logic [15:0] count;

  rct_pkg::scan_t scan_next;

  // The first matching valid entry wins, and the lowest free entry is noted.
  always_comb begin
    scan_next = scan_in;
    if (valid && (node == node_id) && !scan_in.hit) begin
      scan_next.hit       = 1'b1;
      scan_next.hit_idx   = MY_IDX;
      scan_next.hit_boot  = boot;
      scan_next.hit_count = count;
    end
    if (!valid && !scan_in.free_hit) begin
      scan_next.free_hit = 1'b1;
      scan_next.free_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
    end else begin
      scan_out <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && (wr.idx == MY_IDX)) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == MY_IDX)) begin
      node  <= wr.node;
      boot  <= wr.boot;
      count <= wr.count;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/replay_counter_table.sv -----
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | rct_pkg::req_t
// rsp     | out       | rsp_valid, rsp_stall | rct_pkg::rsp_t
//
// A request passes the launch register, then one register per cell as the lookup token
// walks the row, then the decide state, where its result and table write are made.
// The next request is taken once the decide cycle has written the table.
// Reset clears all entry valid bits at once; no clearing pass is needed.
// A waiting result holds the decide cycle while rsp_stall is high.
// Depends on rct_pkg and rct_cell.
`default_nettype none

module replay_counter_table #(
  parameter int TABLE_ENTRIES = rct_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire rct_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output rct_pkg::rsp_t      rsp
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t state, state_next;

  rct_pkg::req_t  req_q;
  logic           start;
  rct_pkg::scan_t chain [0:TABLE_ENTRIES];
  rct_pkg::scan_t tail;
  rct_pkg::wr_t   wr;
  rct_pkg::rsp_t  rsp_next;
  logic           req_take;
  logic           decide_go;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign decide_go = (state == S_DECIDE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = start;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    rct_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .node_id (req_q.node_id),
      .scan_in (chain[i]),
      .wr      (wr),
      .scan_out(chain[i+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req_take) state_next = S_SCAN;
      S_SCAN:   if (chain[TABLE_ENTRIES].valid) state_next = S_DECIDE;
      S_DECIDE: if (decide_go) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start <= 1'b0;
    end else begin
      state <= state_next;
      start <= req_take;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      req_q <= req;
    end
    if (chain[TABLE_ENTRIES].valid) begin
      tail <= chain[TABLE_ENTRIES];
    end
  end

  // Verdict and table write for the finished lookup.
  always_comb begin
    logic [31:0] eb;
    logic [15:0] ec;
    rsp_next  = '0;
    wr        = '0;
    wr.node   = req_q.node_id;
    eb        = tail.hit_boot;
    ec        = tail.hit_count;
    wr.idx    = tail.hit_idx;
    if (!tail.hit) begin
      eb     = '0;
      ec     = '0;
      wr.idx = tail.free_idx;
    end
    wr.boot  = eb;
    wr.count = ec;
    if (req_q.func == rct_pkg::FUNC_QUERY) begin
      if (tail.hit) begin
        rsp_next.verdict      = rct_pkg::V_QHIT;
        rsp_next.stored_count = tail.hit_count;
      end else begin
        rsp_next.verdict = rct_pkg::V_QMISS;
      end
    end else if (!tail.hit && !tail.free_hit) begin
      rsp_next.accepted = 1'b1;
      rsp_next.verdict  = rct_pkg::V_UNTRACKED;
    end else begin
      // A freshly claimed entry is written even when the packet is rejected.
      wr.en = decide_go && !tail.hit;
      if (req_q.boot_value != eb) begin
        wr.en                 = decide_go;
        wr.boot               = req_q.boot_value;
        wr.count              = req_q.frame_count;
        rsp_next.accepted     = 1'b1;
        rsp_next.verdict      = rct_pkg::V_REBOOT;
        rsp_next.stored_count = req_q.frame_count;
      end else if (req_q.frame_count > ec) begin
        wr.en                 = decide_go;
        wr.count              = req_q.frame_count;
        rsp_next.accepted     = 1'b1;
        rsp_next.verdict      = rct_pkg::V_ADVANCED;
        rsp_next.stored_count = req_q.frame_count;
      end else begin
        rsp_next.verdict      = rct_pkg::V_REJECTED;
        rsp_next.stored_count = ec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (decide_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide_go) begin
      rsp <= rsp_next;
    end
  end

`ifndef ASSERT_OFF
  a_tail_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[TABLE_ENTRIES].valid |-> (state == S_SCAN))
    else $error("lookup token left the row outside a scan");

  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (req_q.func == rct_pkg::FUNC_CHECK) && (state == S_DECIDE))
    else $error("table written outside the decide cycle of a check");

  a_accept_matches_verdict: assert property (@(posedge clk) disable iff (rst)
    decide_go |=> rsp.accepted == ((rsp.verdict == rct_pkg::V_ADVANCED) ||
                                   (rsp.verdict == rct_pkg::V_REBOOT) ||
                                   (rsp.verdict == rct_pkg::V_UNTRACKED)))
    else $error("accepted flag disagrees with verdict");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/replay_counter_table_tb.sv -----
// Self-checking testbench for replay_counter_table: a predictor of the node table
// checks every result of the rsp channel against its own verdict for each request.
// Depends on rct_pkg and the replay_counter_table RTL.
`default_nettype none

module replay_counter_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = rct_pkg::TABLE_ENTRIES_DEF;
  localparam int RANDOM_PER_PHASE = 400;
  localparam int CYCLE_LIMIT = 400000;

  // Mirror of the node table plus the verdicts still owed by the block.
  class guard_table;
    bit            slot_used[ENTRIES];
    logic [31:0]   slot_node[ENTRIES];
    logic [31:0]   slot_boot[ENTRIES];
    logic [15:0]   slot_count[ENTRIES];
    rct_pkg::rsp_t pending_verdicts[$];
    int            errors;

    function new();
      errors = 0;
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_node[i] = '0;
        slot_boot[i] = '0;
        slot_count[i] = '0;
      end
    endfunction

    function int find_node(logic [31:0] id);
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i] && slot_node[i] == id) return i;
      end
      return -1;
    endfunction

    function void take_packet(rct_pkg::req_t r);
      rct_pkg::rsp_t want;
      int            idx;
      want = '0;
      idx = find_node(r.node_id);
      if (r.func == rct_pkg::FUNC_QUERY) begin
        if (idx >= 0) begin
          want.verdict = rct_pkg::V_QHIT;
          want.stored_count = slot_count[idx];
        end else begin
          want.verdict = rct_pkg::V_QMISS;
        end
      end else begin
        // An unknown node claims the lowest free slot with boot 0 and count 0.
        if (idx < 0) begin
          for (int i = 0; i < ENTRIES && idx < 0; i++) begin
            if (!slot_used[i]) idx = i;
          end
          if (idx >= 0) begin
            slot_used[idx] = 1'b1;
            slot_node[idx] = r.node_id;
            slot_boot[idx] = '0;
            slot_count[idx] = '0;
          end
        end
        if (idx < 0) begin
          want.accepted = 1'b1;
          want.verdict = rct_pkg::V_UNTRACKED;
        end else if (r.boot_value != slot_boot[idx]) begin
          slot_boot[idx] = r.boot_value;
          slot_count[idx] = r.frame_count;
          want.accepted = 1'b1;
          want.verdict = rct_pkg::V_REBOOT;
          want.stored_count = r.frame_count;
        end else if (r.frame_count > slot_count[idx]) begin
          slot_count[idx] = r.frame_count;
          want.accepted = 1'b1;
          want.verdict = rct_pkg::V_ADVANCED;
          want.stored_count = r.frame_count;
        end else begin
          want.verdict = rct_pkg::V_REJECTED;
          want.stored_count = slot_count[idx];
        end
      end
      pending_verdicts.push_back(want);
    endfunction

    function void match_verdict(rct_pkg::rsp_t got);
      rct_pkg::rsp_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with nothing expected: accepted %0d verdict %0d count %0d",
                 $time, got.accepted, got.verdict, got.stored_count);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.accepted !== want.accepted) begin
        $display("%0t: accepted expected %0d actual %0d", $time, want.accepted, got.accepted);
        errors++;
      end
      if (got.verdict !== want.verdict) begin
        $display("%0t: verdict expected %0d actual %0d", $time, want.verdict, got.verdict);
        errors++;
      end
      if (got.stored_count !== want.stored_count) begin
        $display("%0t: stored_count expected %0d actual %0d", $time, want.stored_count,
                 got.stored_count);
        errors++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_stall;
  rct_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_stall;
  rct_pkg::rsp_t rsp;

  guard_table  sb;
  logic [31:0] pool[ENTRIES];
  int          send_pct;
  int          recv_pct;

  replay_counter_table uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic rct_pkg::req_t mk(logic f, logic [31:0] n, logic [31:0] b,
                                       logic [15:0] c);
    rct_pkg::req_t r;
    r.func = f;
    r.node_id = n;
    r.boot_value = b;
    r.frame_count = c;
    return r;
  endfunction

  // Mostly well-formed traffic from the tracked nodes: counts that move forward,
  // with replays, reboots, queries and strangers mixed in.
  function automatic rct_pkg::req_t random_packet();
    rct_pkg::req_t r;
    int            idx;
    int            roll;
    int            head;
    r.func = rct_pkg::FUNC_CHECK;
    r.node_id = pool[$urandom_range(ENTRIES - 1)];
    r.boot_value = $urandom();
    r.frame_count = 16'($urandom());
    roll = $urandom_range(99);
    idx = sb.find_node(r.node_id);
    if (roll < 15) begin
      r.func = rct_pkg::FUNC_QUERY;
    end else if (roll < 20) begin
      r.func = rct_pkg::FUNC_QUERY;
      r.node_id = $urandom();
    end else if (roll < 27) begin
      r.node_id = $urandom();
    end else if (roll >= 35 && idx >= 0) begin
      r.boot_value = sb.slot_boot[idx];
      head = 32'hFFFF - int'(sb.slot_count[idx]);
      if (roll < 80 && head > 0) begin
        r.frame_count = 16'(int'(sb.slot_count[idx]) +
                            $urandom_range(head < 300 ? head : 300, 1));
      end else begin
        r.frame_count = 16'($urandom_range(int'(sb.slot_count[idx])));
      end
    end
    return r;
  endfunction

  task automatic send_req(input rct_pkg::req_t r);
    while ($urandom_range(99) < send_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall !== 1'b0);
    sb.take_packet(r);
  endtask

  // Result side: check each transfer, then pick the stall for the next cycle.
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid === 1'b1 && !rsp_stall) sb.match_verdict(rsp);
      rsp_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("replay_counter_table_tb: done, errors");
    $finish;
  end

  initial begin
    sb = new();
    send_pct = 34;
    recv_pct = 79;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < ENTRIES; k++) pool[k] = {16'(k), 16'($urandom())};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_req(mk(rct_pkg::FUNC_QUERY, pool[0], 32'hFFFF_FFFF, 16'hFFFF));
    // New node with boot zero: the claimed slot already matches, so count 0 is a replay.
    send_req(mk(rct_pkg::FUNC_CHECK, pool[0], 32'h0, 16'h0000));
    send_req(mk(rct_pkg::FUNC_CHECK, pool[0], 32'h0, 16'h0001));
    send_req(mk(rct_pkg::FUNC_CHECK, pool[0], 32'h0, 16'h0001));
    send_req(mk(rct_pkg::FUNC_CHECK, pool[0], 32'h0, 16'hFFFF));
    send_req(mk(rct_pkg::FUNC_QUERY, pool[0], 32'h0, 16'h0000));
    send_req(mk(rct_pkg::FUNC_CHECK, pool[1], 32'hFFFF_FFFF, 16'h0000));
    send_req(mk(rct_pkg::FUNC_CHECK, pool[1], 32'hFFFF_FFFF, 16'h0000));
    send_req(mk(rct_pkg::FUNC_CHECK, pool[1], 32'h1234_5678, 16'h0005));
    send_req(mk(rct_pkg::FUNC_CHECK, pool[1], 32'h1234_5678, 16'h0004));
    for (int k = 2; k < ENTRIES; k++) begin
      send_req(mk(rct_pkg::FUNC_CHECK, pool[k], $urandom(), 16'($urandom())));
    end
    // The table is full now: strangers pass untracked and stay unknown.
    send_req(mk(rct_pkg::FUNC_CHECK, 32'h5A5A_A5A5, $urandom(), 16'hFFFF));
    send_req(mk(rct_pkg::FUNC_QUERY, 32'h5A5A_A5A5, 32'h0, 16'h0000));
    send_req(mk(rct_pkg::FUNC_CHECK, pool[0], 32'h0, 16'hFFFF));
    send_req(mk(rct_pkg::FUNC_QUERY, pool[ENTRIES - 1], $urandom(), 16'($urandom())));
    send_req(mk(rct_pkg::FUNC_CHECK, pool[1], 32'h1234_5678, 16'h0000));

    for (int ph = 0; ph < 3; ph++) begin
      send_pct = (ph == 0) ? 34 : (ph == 1) ? 79 : 0;
      recv_pct = (ph == 0) ? 79 : (ph == 1) ? 34 : 0;
      repeat (RANDOM_PER_PHASE) send_req(random_packet());
    end
    req_valid <= 1'b0;

    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (ENTRIES + 6) @(posedge clk);
    if (sb.errors == 0) begin
      $display("replay_counter_table_tb: done, clean");
    end else begin
      $display("replay_counter_table_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
